[src/priority_ordered_filter_table_assert.svh]
// Assertion macros shared by the filter table RTL.
`ifndef PRIORITY_ORDERED_FILTER_TABLE_ASSERT_SVH
`define PRIORITY_ORDERED_FILTER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define POF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define POF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/pof_pkg.sv]
// Shared constants, codes and types of the priority-ordered filter table.
`timescale 1ns / 1ps

package pof_pkg;

   // Default table geometry.
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF    = 32;

   // Fixed field widths.
   localparam int IN_KEY_W  = 32;
   localparam int PRIO_W    = 64;
   localparam int HANDLE_W  = 32;
   localparam int SLOT_W    = 5;
   localparam int STATUS_W  = 3;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 8;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   // Outcome of one entry compare.
   typedef struct packed {
      logic key_eq;
      logic prio_gt;
   } cmp_res_type;

endpackage

[src/pof_mem.sv]
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps

module pof_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/pof_cmp.sv]
// Shared compare unit: key equality and signed priority order of one entry.
`timescale 1ns / 1ps

module pof_cmp #(
   parameter int KEY_BITS = 32
) (
   input  logic [KEY_BITS-1:0]              ent_key,
   input  logic signed [pof_pkg::PRIO_W-1:0] ent_prio,
   input  logic [KEY_BITS-1:0]              req_key,
   input  logic signed [pof_pkg::PRIO_W-1:0] req_prio,
   output pof_pkg::cmp_res_type             res
);

   import pof_pkg::*;

   // The new entry goes in front of the first entry of strictly lower priority.
   assign res.key_eq  = (ent_key == req_key);
   assign res.prio_gt = (req_prio > ent_prio);

endmodule

[src/priority_ordered_filter_table.sv]
// The scan reads each stored entry in turn, then a move copies one entry per cycle.
// Not found and full respond after the scan; an update writes in place, a remove shifts the later
// entries up and an insert shifts the later entries down before it writes.
// A new request is taken in the cycle after the response is delivered, so requests never overlap.
// Reset (synchronous, active high) empties the table; entry contents need no clearing.
`timescale 1ns / 1ps
`include "priority_ordered_filter_table_assert.svh"

module priority_ordered_filter_table #(
   parameter int TABLE_DEPTH = pof_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = pof_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // remove_req
   input  logic                              req_tuser,
   // class_key[31:0], prio[95:32], entry_handle[127:96]
   input  logic [pof_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot_index[4:0], status[7:5]
   output logic [pof_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   import pof_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = KEY_BITS + PRIO_W + HANDLE_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_MOVE  = 5'b00100,
      S_WRITE = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      rm_ff, rm_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic signed [PRIO_W-1:0]  prio_ff, prio_in;
   logic [HANDLE_W-1:0]       handle_ff, handle_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          found_idx_ff, found_idx_in;
   logic                      pos_found_ff, pos_found_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic [IDX_W-1:0]          mv_src_ff, mv_src_in;
   logic [CNT_W-1:0]          mv_left_ff, mv_left_in;
   logic                      pend_ff, pend_in;
   logic [IDX_W-1:0]          pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]          tgt_ff, tgt_in;
   logic [CNT_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [ENTRY_W-1:0]        mem_wdata;
   logic                      mem_re;
   logic [IDX_W-1:0]          mem_raddr;
   logic [ENTRY_W-1:0]        mem_rdata;
   cmp_res_type               cmp_res;
   logic [IDX_W-1:0]          ins_idx;

   // Entry storage, laid out as key, priority, handle from the top bit down.
   pof_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Compare the entry just read against the held request.
   pof_cmp #(
      .KEY_BITS (KEY_BITS)
   ) u_cmp (
      .ent_key  (mem_rdata[ENTRY_W-1 -: KEY_BITS]),
      .ent_prio (mem_rdata[HANDLE_W +: PRIO_W]),
      .req_key  (key_ff),
      .req_prio (prio_ff),
      .res      (cmp_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {rsp_status_ff, SLOT_W'(rsp_slot_ff)};

   // Insert position: first entry of lower priority, else the end of the table.
   assign ins_idx = pos_found_ff ? pos_ff : count_ff[IDX_W-1:0];

   // Sequencer: scan, move, write and respond.
   always_comb begin
      state_in      = state_ff;
      rm_in         = rm_ff;
      key_in        = key_ff;
      prio_in       = prio_ff;
      handle_in     = handle_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      pos_found_in  = pos_found_ff;
      pos_in        = pos_ff;
      mv_src_in     = mv_src_ff;
      mv_left_in    = mv_left_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      tgt_in        = tgt_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = pend_addr_ff;
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = scan_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rm_in        = req_tuser;
               key_in       = KEY_BITS'(req_tdata[IN_KEY_W-1:0]);
               prio_in      = req_tdata[IN_KEY_W +: PRIO_W];
               handle_in    = req_tdata[IN_KEY_W + PRIO_W +: HANDLE_W];
               scan_in      = '0;
               found_in     = 1'b0;
               pos_found_in = 1'b0;
               state_in     = S_SCAN;
            end
         end

         S_SCAN: begin
            // Issue one read per cycle while entries remain.
            if (scan_ff < count_ff) begin
               mem_re     = 1'b1;
               scan_in    = scan_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
            end
            // Judge the entry read in the previous cycle; the first hit wins.
            if (chk_vld_ff) begin
               if (cmp_res.key_eq && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = chk_idx_ff;
               end
               if (cmp_res.prio_gt && !pos_found_ff) begin
                  pos_found_in = 1'b1;
                  pos_in       = chk_idx_ff;
               end
            end
            // Scan finished: pick the operation.
            if (!(scan_ff < count_ff) && !chk_vld_ff) begin
               if (rm_ff) begin
                  if (!found_ff) begin
                     rsp_slot_in   = count_ff;
                     rsp_status_in = ST_NOTFOUND;
                     state_in      = S_RESP;
                  end else begin
                     mv_src_in     = found_idx_ff + 1'b1;
                     mv_left_in    = count_ff - 1'b1 - CNT_W'(found_idx_ff);
                     rsp_slot_in   = CNT_W'(found_idx_ff);
                     rsp_status_in = ST_REMOVED;
                     state_in      = S_MOVE;
                  end
               end else if (found_ff) begin
                  tgt_in        = found_idx_ff;
                  rsp_slot_in   = CNT_W'(found_idx_ff);
                  rsp_status_in = ST_UPDATED;
                  state_in      = S_WRITE;
               end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  rsp_slot_in   = count_ff;
                  rsp_status_in = ST_FULL;
                  state_in      = S_RESP;
               end else begin
                  tgt_in        = ins_idx;
                  mv_src_in     = count_ff[IDX_W-1:0] - 1'b1;
                  mv_left_in    = count_ff - CNT_W'(ins_idx);
                  rsp_slot_in   = CNT_W'(ins_idx);
                  rsp_status_in = ST_INSERTED;
                  state_in      = S_MOVE;
               end
            end
         end

         S_MOVE: begin
            // Read the next source entry; a remove walks up, an insert walks down.
            mem_raddr = mv_src_ff;
            if (mv_left_ff != '0) begin
               mem_re     = 1'b1;
               mv_left_in = mv_left_ff - 1'b1;
               pend_in    = 1'b1;
               if (rm_ff) begin
                  mv_src_in    = mv_src_ff + 1'b1;
                  pend_addr_in = mv_src_ff - 1'b1;
               end else begin
                  mv_src_in    = mv_src_ff - 1'b1;
                  pend_addr_in = mv_src_ff + 1'b1;
               end
            end
            // Write the entry read in the previous cycle one slot over.
            mem_we = pend_ff;
            if ((mv_left_ff == '0) && !pend_ff) begin
               if (rm_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end

         S_WRITE: begin
            // Store the request's entry at its slot; a new key grows the table.
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = {key_ff, prio_ff, handle_ff};
            if (!found_ff) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         pos_found_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         pos_found_ff <= pos_found_in;
         pend_ff      <= pend_in;
      end
   end

   // Request and working registers.
   always_ff @(posedge clock) begin
      rm_ff         <= rm_in;
      key_ff        <= key_in;
      prio_ff       <= prio_in;
      handle_ff     <= handle_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      found_idx_ff  <= found_idx_in;
      pos_ff        <= pos_in;
      mv_src_ff     <= mv_src_in;
      mv_left_ff    <= mv_left_in;
      pend_addr_ff  <= pend_addr_in;
      tgt_ff        <= tgt_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Checks on the table bookkeeping.
   `POF_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "entry count overflow")
   `POF_ASSERT_SAME(a_full_status, rsp_tvalid && (rsp_status_ff == ST_FULL), count_ff == CNT_W'(TABLE_DEPTH), "full reported with room left")
   `POF_ASSERT_SAME(a_insert_slot, rsp_tvalid && (rsp_status_ff == ST_INSERTED), rsp_slot_ff < count_ff, "insert slot outside table")
   `POF_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready && !rsp_tvalid, "request overlap")

endmodule
